[hw/rtl/hbp_pkg.sv]
// hbp_pkg: shared types and constants of the hybrid branch predictor
// transfer structs, config register indexes, mode codes, fsm states
// no dependencies
package hbp_pkg;

  // default table sizes in index bits
  localparam int DEF_BIMODAL_MAX_BITS = 12;
  localparam int DEF_GSHARE_MAX_BITS  = 14;
  localparam int DEF_CHOOSER_MAX_BITS = 12;

  // config port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_ADDR_W-1:0] CFG_MODE         = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BIMODAL_BITS = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_GSHARE_BITS  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_HISTORY_BITS = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_CHOOSER_BITS = 3'd4;

  typedef enum logic [1:0] {
    MODE_BIMODAL = 2'd0,
    MODE_GSHARE  = 2'd1,
    MODE_HYBRID  = 2'd2
  } mode_t;

  // register reset values
  localparam mode_t      RST_MODE         = MODE_HYBRID;
  localparam logic [3:0] RST_BIMODAL_BITS = 4'd12;
  localparam logic [3:0] RST_GSHARE_BITS  = 4'd14;
  localparam logic [3:0] RST_HISTORY_BITS = 4'd8;
  localparam logic [3:0] RST_CHOOSER_BITS = 4'd12;

  // table reset values
  localparam logic [1:0] CTR_RESET     = 2'd2;
  localparam logic [1:0] CHOOSER_RESET = 2'd1;
  localparam logic [1:0] CTR_MAX       = 2'd3;
  localparam logic [1:0] CTR_MIN       = 2'd0;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [31:0] branch_pc;
    logic        taken;
  } in_t;

  typedef struct packed {
    logic        predicted_taken;
    logic        mispredicted;
    logic        used_gshare;
    logic [31:0] prediction_total;
    logic [31:0] mispredict_total;
  } out_t;

  // counters read back from the tables, into the update logic
  typedef struct packed {
    mode_t      mode;
    logic       taken;
    logic [1:0] bctr;
    logic [1:0] gctr;
    logic [1:0] cctr;
  } upd_in_t;

  // trained counters and write enables, out of the update logic
  typedef struct packed {
    logic       pred;
    logic       miss;
    logic       use_g;
    logic       b_we;
    logic       g_we;
    logic       c_we;
    logic [1:0] bctr_new;
    logic [1:0] gctr_new;
    logic [1:0] cctr_new;
  } upd_out_t;

endpackage

[hw/rtl/hybrid_branch_predictor.sv]
// hybrid_branch_predictor: top level, bimodal / gshare / tournament predictor
// depends on hbp_pkg, hbp_ram, hbp_index, hbp_update
//
// channel   direction  handshake            payload
// branch    in         start & !busy        in_t  (branch_pc, taken)
// result    out        done, one cycle      out_t (prediction and totals)
// config    in         cfg_we               cfg_addr, cfg_data
//
// a branch is read from the tables in the accept cycle, trained and written back
// in the next (ST_UPDATE); the result strobes in the cycle after that, while a
// new branch may already be taken. the three counter rams have one read and one
// write port each. after reset the tables are cleared one entry a cycle, over
// 2**max(BIMODAL_MAX_BITS, GSHARE_MAX_BITS, CHOOSER_MAX_BITS) entries (16384 by
// default), with busy high. the receiver cannot stall results.
module hybrid_branch_predictor
  import hbp_pkg::*;
#(
  parameter int BIMODAL_MAX_BITS = DEF_BIMODAL_MAX_BITS,
  parameter int GSHARE_MAX_BITS  = DEF_GSHARE_MAX_BITS,
  parameter int CHOOSER_MAX_BITS = DEF_CHOOSER_MAX_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  in_t                   branch,
  output logic                  done,
  output out_t                  result,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int BG_MAX  = (BIMODAL_MAX_BITS > GSHARE_MAX_BITS) ?
                           BIMODAL_MAX_BITS : GSHARE_MAX_BITS;
  localparam int CLR_BITS = (BG_MAX > CHOOSER_MAX_BITS) ? BG_MAX : CHOOSER_MAX_BITS;

  state_t state;
  state_t state_next;

  mode_t      mode;
  logic [3:0] bimodal_bits;
  logic [3:0] gshare_bits;
  logic [3:0] history_bits;
  logic [3:0] chooser_bits;

  logic [GSHARE_MAX_BITS-1:0]  history;
  logic [GSHARE_MAX_BITS-1:0]  history_next;
  logic                        history_upd;
  logic [CLR_BITS-1:0]         clr_cnt;
  logic [31:0]                 branch_count;
  logic [31:0]                 miss_count;

  logic [BIMODAL_MAX_BITS-1:0] bidx;
  logic [GSHARE_MAX_BITS-1:0]  gidx;
  logic [CHOOSER_MAX_BITS-1:0] cidx;
  logic [BIMODAL_MAX_BITS-1:0] bidx_q;
  logic [GSHARE_MAX_BITS-1:0]  gidx_q;
  logic [CHOOSER_MAX_BITS-1:0] cidx_q;
  logic                        taken_q;

  logic                        accept;
  logic                        clearing;
  logic                        updating;

  logic                        b_we;
  logic                        g_we;
  logic                        c_we;
  logic [BIMODAL_MAX_BITS-1:0] b_waddr;
  logic [GSHARE_MAX_BITS-1:0]  g_waddr;
  logic [CHOOSER_MAX_BITS-1:0] c_waddr;
  logic [1:0]                  b_wdata;
  logic [1:0]                  g_wdata;
  logic [1:0]                  c_wdata;
  logic [1:0]                  b_rdata;
  logic [1:0]                  g_rdata;
  logic [1:0]                  c_rdata;

  upd_in_t  upd_in;
  upd_out_t upd_out;

  // fsm
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    clearing   = 1'b0;
    updating   = 1'b0;
    case (state)
      ST_CLEAR: begin
        clearing = 1'b1;
        if (clr_cnt == {CLR_BITS{1'b1}}) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        updating   = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= RST_MODE;
      bimodal_bits <= RST_BIMODAL_BITS;
      gshare_bits  <= RST_GSHARE_BITS;
      history_bits <= RST_HISTORY_BITS;
      chooser_bits <= RST_CHOOSER_BITS;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MODE:         mode         <= mode_t'(cfg_data[1:0]);
        CFG_BIMODAL_BITS: bimodal_bits <= cfg_data[3:0];
        CFG_GSHARE_BITS:  gshare_bits  <= cfg_data[3:0];
        CFG_HISTORY_BITS: history_bits <= cfg_data[3:0];
        CFG_CHOOSER_BITS: chooser_bits <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  hbp_index #(
    .BIMODAL_MAX_BITS (BIMODAL_MAX_BITS),
    .GSHARE_MAX_BITS  (GSHARE_MAX_BITS),
    .CHOOSER_MAX_BITS (CHOOSER_MAX_BITS)
  ) u_index (
    .branch_pc    (branch.branch_pc),
    .taken        (branch.taken),
    .mode         (mode),
    .bimodal_bits (bimodal_bits),
    .gshare_bits  (gshare_bits),
    .history_bits (history_bits),
    .chooser_bits (chooser_bits),
    .history      (history),
    .bidx         (bidx),
    .gidx         (gidx),
    .cidx         (cidx),
    .history_next (history_next),
    .history_upd  (history_upd)
  );

  // history is read only at accept, so it can move on right away
  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
    end else if (accept && history_upd) begin
      history <= history_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bidx_q  <= bidx;
      gidx_q  <= gidx;
      cidx_q  <= cidx;
      taken_q <= branch.taken;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign upd_in.mode  = mode;
  assign upd_in.taken = taken_q;
  assign upd_in.bctr  = b_rdata;
  assign upd_in.gctr  = g_rdata;
  assign upd_in.cctr  = c_rdata;

  hbp_update u_update (
    .upd_in  (upd_in),
    .upd_out (upd_out)
  );

  // write back; the next read comes after the write has landed, no forwarding
  always_comb begin
    b_we    = clearing || (updating && upd_out.b_we);
    g_we    = clearing || (updating && upd_out.g_we);
    c_we    = clearing || (updating && upd_out.c_we);
    b_waddr = clearing ? clr_cnt[BIMODAL_MAX_BITS-1:0] : bidx_q;
    g_waddr = clearing ? clr_cnt[GSHARE_MAX_BITS-1:0]  : gidx_q;
    c_waddr = clearing ? clr_cnt[CHOOSER_MAX_BITS-1:0] : cidx_q;
    b_wdata = clearing ? CTR_RESET     : upd_out.bctr_new;
    g_wdata = clearing ? CTR_RESET     : upd_out.gctr_new;
    c_wdata = clearing ? CHOOSER_RESET : upd_out.cctr_new;
  end

  hbp_ram #(.WIDTH(2), .DEPTH(2 ** BIMODAL_MAX_BITS)) u_bimodal_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (accept),
    .raddr (bidx),
    .rdata (b_rdata)
  );

  hbp_ram #(.WIDTH(2), .DEPTH(2 ** GSHARE_MAX_BITS)) u_gshare_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .re    (accept),
    .raddr (gidx),
    .rdata (g_rdata)
  );

  hbp_ram #(.WIDTH(2), .DEPTH(2 ** CHOOSER_MAX_BITS)) u_chooser_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (accept),
    .raddr (cidx),
    .rdata (c_rdata)
  );

  // totals and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      branch_count <= '0;
      miss_count   <= '0;
      done         <= 1'b0;
    end else begin
      done <= updating;
      if (updating) begin
        branch_count <= branch_count + 32'd1;
        miss_count   <= miss_count + {31'd0, upd_out.miss};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (updating) begin
      result.predicted_taken  <= upd_out.pred;
      result.mispredicted     <= upd_out.miss;
      result.used_gshare      <= upd_out.use_g;
      result.prediction_total <= branch_count + 32'd1;
      result.mispredict_total <= miss_count + {31'd0, upd_out.miss};
    end
  end

endmodule

[hw/rtl/hbp_ram.sv]
// hbp_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module hbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/hbp_index.sv]
// hbp_index: table index forming and global history shift
// depends on hbp_pkg
module hbp_index
  import hbp_pkg::*;
#(
  parameter int BIMODAL_MAX_BITS = DEF_BIMODAL_MAX_BITS,
  parameter int GSHARE_MAX_BITS  = DEF_GSHARE_MAX_BITS,
  parameter int CHOOSER_MAX_BITS = DEF_CHOOSER_MAX_BITS
) (
  input  logic [31:0]                 branch_pc,
  input  logic                        taken,
  input  mode_t                       mode,
  input  logic [3:0]                  bimodal_bits,
  input  logic [3:0]                  gshare_bits,
  input  logic [3:0]                  history_bits,
  input  logic [3:0]                  chooser_bits,
  input  logic [GSHARE_MAX_BITS-1:0]  history,
  output logic [BIMODAL_MAX_BITS-1:0] bidx,
  output logic [GSHARE_MAX_BITS-1:0]  gidx,
  output logic [CHOOSER_MAX_BITS-1:0] cidx,
  output logic [GSHARE_MAX_BITS-1:0]  history_next,
  output logic                        history_upd
);

  logic [29:0]                 word;
  logic [4:0]                  beff;
  logic [4:0]                  geff;
  logic [4:0]                  ceff;
  logic [4:0]                  heff;
  logic [4:0]                  shamt;
  logic [BIMODAL_MAX_BITS-1:0] bmask;
  logic [GSHARE_MAX_BITS-1:0]  gmask;
  logic [GSHARE_MAX_BITS-1:0]  hmask;
  logic [CHOOSER_MAX_BITS-1:0] cmask;
  logic [GSHARE_MAX_BITS-1:0]  hist_m;
  logic [GSHARE_MAX_BITS-1:0]  gword;
  logic [GSHARE_MAX_BITS-1:0]  taken_bit;

  assign word = branch_pc[31:2];

  // for the tables zero acts as one and above the size saturates; history caps at geff
  always_comb begin
    beff = (bimodal_bits == 4'd0) ? 5'd1 :
           ({1'b0, bimodal_bits} > 5'(BIMODAL_MAX_BITS)) ? 5'(BIMODAL_MAX_BITS) :
           {1'b0, bimodal_bits};
    geff = (gshare_bits == 4'd0) ? 5'd1 :
           ({1'b0, gshare_bits} > 5'(GSHARE_MAX_BITS)) ? 5'(GSHARE_MAX_BITS) :
           {1'b0, gshare_bits};
    ceff = (chooser_bits == 4'd0) ? 5'd1 :
           ({1'b0, chooser_bits} > 5'(CHOOSER_MAX_BITS)) ? 5'(CHOOSER_MAX_BITS) :
           {1'b0, chooser_bits};
    heff = ({1'b0, history_bits} > geff) ? geff : {1'b0, history_bits};
  end

  always_comb begin
    for (int i = 0; i < BIMODAL_MAX_BITS; i++) begin
      bmask[i] = (5'(i) < beff);
    end
    for (int i = 0; i < GSHARE_MAX_BITS; i++) begin
      gmask[i] = (5'(i) < geff);
      hmask[i] = (5'(i) < heff);
    end
    for (int i = 0; i < CHOOSER_MAX_BITS; i++) begin
      cmask[i] = (5'(i) < ceff);
    end
  end

  always_comb begin
    bidx      = word[BIMODAL_MAX_BITS-1:0] & bmask;
    cidx      = word[CHOOSER_MAX_BITS-1:0] & cmask;
    gword     = word[GSHARE_MAX_BITS-1:0] & gmask;
    hist_m    = history & hmask;
    shamt     = geff - heff;
    // history lands on the top heff bits of the gshare index
    gidx      = (gword ^ (hist_m << shamt)) & gmask;
    taken_bit = {{(GSHARE_MAX_BITS-1){1'b0}}, taken};
    history_next = ((hist_m >> 1) | (taken_bit << (heff - 5'd1))) & hmask;
    history_upd  = (mode != MODE_BIMODAL) && (heff != 5'd0);
  end

endmodule

[hw/rtl/hbp_update.sv]
// hbp_update: prediction select and saturating counter training
// depends on hbp_pkg
module hbp_update
  import hbp_pkg::*;
(
  input  upd_in_t  upd_in,
  output upd_out_t upd_out
);

  function automatic logic [1:0] train(input logic [1:0] ctr, input logic up);
    logic [1:0] res;
    res = ctr;
    if (up) begin
      if (ctr != CTR_MAX) res = ctr + 2'd1;
    end else begin
      if (ctr != CTR_MIN) res = ctr - 2'd1;
    end
    return res;
  endfunction

  logic bpred;
  logic gpred;
  logic use_g;
  logic pred;
  logic hybrid;

  always_comb begin
    bpred = upd_in.bctr[1];
    gpred = upd_in.gctr[1];
    case (upd_in.mode)
      MODE_BIMODAL: begin
        use_g  = 1'b0;
        hybrid = 1'b0;
      end
      MODE_GSHARE: begin
        use_g  = 1'b1;
        hybrid = 1'b0;
      end
      default: begin
        // mode 3 behaves as hybrid
        use_g  = upd_in.cctr[1];
        hybrid = 1'b1;
      end
    endcase
    pred = use_g ? gpred : bpred;

    upd_out.pred     = pred;
    upd_out.miss     = pred != upd_in.taken;
    upd_out.use_g    = use_g;
    upd_out.g_we     = use_g;
    upd_out.b_we     = !use_g;
    upd_out.gctr_new = train(upd_in.gctr, upd_in.taken);
    upd_out.bctr_new = train(upd_in.bctr, upd_in.taken);
    // chooser only moves when the two predictors disagree
    upd_out.c_we     = hybrid && (gpred != bpred);
    upd_out.cctr_new = train(upd_in.cctr, gpred == upd_in.taken);
  end

endmodule

[hw/rtl/hbp_checker.sv]
// hbp_checker: port level assertions for hybrid_branch_predictor, bound to the top
// depends on hbp_pkg and hybrid_branch_predictor
module hbp_checker
  import hbp_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // every accepted branch gives its result after the update state and the done register
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("no result two cycles after a branch transfer");

  // a result shows only while the predictor is idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // no result strobe directly follows another
  a_done_spacing: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe in two adjacent cycles");

  // tables are being cleared after reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> (busy && !done))
    else $error("not busy clearing after reset");

endmodule

bind hybrid_branch_predictor hbp_checker u_hbp_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
